// ===== hdl/agbw_pkg.sv =====
// ----------------------------------------------------------------------------
// agbw_pkg
// Shared types, constants and blend helpers for the glyph blend writer.
// ----------------------------------------------------------------------------
package agbw_pkg;

    // Full-range framebuffer address: (255 + 255) * 255 + 255 + 255 < 2**17
    localparam int AddrW    = 17;
    localparam int PixAddrW = 14;
    localparam int ChanW    = 6;   // every channel is carried at green width
    localparam int ProdW    = 14;  // 8-bit coverage times 6-bit magnitude

    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = 2;
    localparam int QueueCntW  = 3;

    localparam logic [5:0] RedMask   = 6'h1F;
    localparam logic [5:0] GreenMask = 6'h3F;
    localparam logic [5:0] BlueMask  = 6'h1F;
    localparam int         RedShift  = 11;
    localparam int         GreenShift = 5;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_FG_COLOR   = 2'd0,
        REG_BG_COLOR   = 2'd1,
        REG_ROW_STRIDE = 2'd2
    } cfg_reg_e;

    typedef struct packed {
        logic [15:0] fg_color;
        logic [15:0] bg_color;
        logic [7:0]  row_stride;
    } cfg_t;

    // Word handed from the front to the back
    typedef struct packed {
        logic [7:0]          coverage;
        logic [PixAddrW-1:0] pixel_addr;
        logic                addr_overflow;
        logic                glyph_last;
    } pix_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // Exact floor(m / 255) for m below 64 * 255; the 6-bit result wraps above that
    function automatic logic [ChanW-1:0] div255(input logic [ProdW-1:0] m);
        logic [ProdW:0] t;
        t = {1'b0, m} + (ProdW+1)'(1) + (ProdW+1)'(m[ProdW-1:8]);
        return t[ProdW-1:8];
    endfunction

    // bg +/- quotient; the result stays between bg and fg
    function automatic logic [ChanW-1:0] apply_q(input logic [ChanW-1:0] bg,
                                                 input logic [ChanW-1:0] q,
                                                 input logic             neg);
        return neg ? (bg - q) : (bg + q);
    endfunction

endpackage

// ===== hdl/agbw_front.sv =====
// ----------------------------------------------------------------------------
// agbw_front
// Glyph walker: latches the origin and size, keeps column and line counters,
// computes the framebuffer address and pushes one word per accepted item.
// ----------------------------------------------------------------------------
module agbw_front #(
    parameter int BUFFER_DEPTH = 16384
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  agbw_pkg::cfg_t       cfg,
    input  logic                 in_accept,
    input  logic [7:0]           coverage,
    input  logic                 glyph_start,
    input  logic [7:0]           origin_x,
    input  logic [7:0]           origin_y,
    input  logic [7:0]           glyph_width,
    input  logic [7:0]           glyph_height,
    output agbw_pkg::pix_item_t  push_item
);

    localparam logic [agbw_pkg::AddrW-1:0] DepthVal = agbw_pkg::AddrW'(BUFFER_DEPTH);

    logic [7:0] col_reg,    col_next;
    logic [7:0] line_reg,   line_next;
    logic [7:0] base_x_reg, base_x_next;
    logic [7:0] base_y_reg, base_y_next;
    logic [7:0] width_reg,  width_next;
    logic [7:0] height_reg, height_next;

    logic [7:0] eff_col, eff_line, eff_x, eff_y, eff_w, eff_h;
    logic [8:0] row;
    logic [agbw_pkg::AddrW-1:0] addr;
    logic       last_col, last_line, ovf;

    // A glyph start overrides the stored walk state for this pixel
    always_comb begin
        eff_col  = glyph_start ? 8'd0 : col_reg;
        eff_line = glyph_start ? 8'd0 : line_reg;
        eff_x    = glyph_start ? origin_x : base_x_reg;
        eff_y    = glyph_start ? origin_y : base_y_reg;
        eff_w    = glyph_start ? glyph_width : width_reg;
        eff_h    = glyph_start ? glyph_height : height_reg;
    end

    // Address: (y + line) * stride + x + col, flagged at the buffer depth
    always_comb begin
        row  = {1'b0, eff_y} + {1'b0, eff_line};
        addr = agbw_pkg::AddrW'(row * cfg.row_stride)
             + agbw_pkg::AddrW'(eff_x) + agbw_pkg::AddrW'(eff_col);
        ovf  = addr >= DepthVal;
    end

    assign last_col  = eff_col  == (eff_w - 8'd1);
    assign last_line = eff_line == (eff_h - 8'd1);

    always_comb begin
        push_item.coverage      = coverage;
        push_item.pixel_addr    = ovf ? '0 : addr[agbw_pkg::PixAddrW-1:0];
        push_item.addr_overflow = ovf;
        push_item.glyph_last    = last_col && last_line;
    end

    // Counter advance; wraps back to the glyph corner after the last pixel
    always_comb begin
        col_next    = col_reg;
        line_next   = line_reg;
        base_x_next = base_x_reg;
        base_y_next = base_y_reg;
        width_next  = width_reg;
        height_next = height_reg;
        if (in_accept) begin
            base_x_next = eff_x;
            base_y_next = eff_y;
            width_next  = eff_w;
            height_next = eff_h;
            if (last_col) begin
                col_next  = 8'd0;
                line_next = last_line ? 8'd0 : eff_line + 8'd1;
            end else begin
                col_next  = eff_col + 8'd1;
                line_next = eff_line;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg    <= 8'd0;
            line_reg   <= 8'd0;
            base_x_reg <= 8'd0;
            base_y_reg <= 8'd0;
            width_reg  <= 8'd1;
            height_reg <= 8'd1;
        end else begin
            col_reg    <= col_next;
            line_reg   <= line_next;
            base_x_reg <= base_x_next;
            base_y_reg <= base_y_next;
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

endmodule

// ===== hdl/agbw_queue.sv =====
// ----------------------------------------------------------------------------
// agbw_queue
// Small register queue between the address front and the blend back.
// ----------------------------------------------------------------------------
module agbw_queue (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     push,
    input  agbw_pkg::pix_item_t      push_item,
    input  logic                     pop,
    output agbw_pkg::pix_item_t      head_item,
    output agbw_pkg::queue_status_t  status
);

    agbw_pkg::pix_item_t slot_reg [agbw_pkg::QueueDepth];

    logic [agbw_pkg::QueuePtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [agbw_pkg::QueuePtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [agbw_pkg::QueueCntW-1:0] count_reg,  count_next;

    assign status.full  = count_reg == agbw_pkg::QueueCntW'(agbw_pkg::QueueDepth);
    assign status.empty = count_reg == '0;
    assign head_item    = slot_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload storage, no reset
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== hdl/agbw_back.sv =====
// ----------------------------------------------------------------------------
// agbw_back
// Blend pipeline: per-channel multiply, divide by 255, repack, byte swap and
// output register.
// ----------------------------------------------------------------------------
module agbw_back (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  agbw_pkg::cfg_t           cfg,
    input  agbw_pkg::pix_item_t      head_item,
    input  agbw_pkg::queue_status_t  q_status,
    output logic                     pop,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [31:0]              m_axis_tdata,
    output logic                     m_axis_tuser,
    output logic                     m_axis_tlast
);

    localparam int CW = agbw_pkg::ChanW;
    localparam int PW = agbw_pkg::ProdW;

    // Stage 1: products
    logic               s1_vld_reg;
    logic [PW-1:0]      s1_mag_reg [3];
    logic [2:0]         s1_neg_reg;
    logic [CW-1:0]      s1_bg_reg  [3];
    logic [agbw_pkg::PixAddrW-1:0] s1_addr_reg;
    logic               s1_ovf_reg;
    logic               s1_last_reg;

    // Output register
    logic               out_vld_reg;
    logic [15:0]        out_word_reg;
    logic [agbw_pkg::PixAddrW-1:0] out_addr_reg;
    logic               out_ovf_reg;
    logic               out_last_reg;

    logic               out_en, s1_en;
    logic [CW-1:0]      fg_ch [3];
    logic [CW-1:0]      bg_ch [3];
    logic [CW:0]        diff  [3];
    logic [CW-1:0]      mag   [3];
    logic [2:0]         neg;
    logic [CW-1:0]      q     [3];
    logic [CW-1:0]      ch    [3];
    logic [15:0]        px;

    // Stall chain: a stage moves when the next one is free or draining
    assign out_en = !out_vld_reg || m_axis_tready;
    assign s1_en  = !s1_vld_reg || out_en;
    assign pop    = s1_en && !q_status.empty;

    // Channel split (red, green, blue) and signed differences
    always_comb begin
        fg_ch[0] = CW'(cfg.fg_color >> agbw_pkg::RedShift)   & agbw_pkg::RedMask;
        fg_ch[1] = CW'(cfg.fg_color >> agbw_pkg::GreenShift) & agbw_pkg::GreenMask;
        fg_ch[2] = CW'(cfg.fg_color)                         & agbw_pkg::BlueMask;
        bg_ch[0] = CW'(cfg.bg_color >> agbw_pkg::RedShift)   & agbw_pkg::RedMask;
        bg_ch[1] = CW'(cfg.bg_color >> agbw_pkg::GreenShift) & agbw_pkg::GreenMask;
        bg_ch[2] = CW'(cfg.bg_color)                         & agbw_pkg::BlueMask;
        for (int i = 0; i < 3; i++) begin
            diff[i] = {1'b0, fg_ch[i]} - {1'b0, bg_ch[i]};
            neg[i]  = diff[i][CW];
            mag[i]  = neg[i] ? CW'(-diff[i]) : diff[i][CW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (s1_en) begin
            s1_vld_reg <= !q_status.empty;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            for (int i = 0; i < 3; i++) begin
                s1_mag_reg[i] <= PW'(head_item.coverage * mag[i]);
                s1_bg_reg[i]  <= bg_ch[i];
            end
            s1_neg_reg  <= neg;
            s1_addr_reg <= head_item.pixel_addr;
            s1_ovf_reg  <= head_item.addr_overflow;
            s1_last_reg <= head_item.glyph_last;
        end
    end

    // Stage 2: quotient toward zero, add background, repack and swap bytes
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            q[i]  = agbw_pkg::div255(s1_mag_reg[i]);
            ch[i] = agbw_pkg::apply_q(s1_bg_reg[i], q[i], s1_neg_reg[i]);
        end
        px = {ch[0][4:0], ch[1][5:0], ch[2][4:0]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_en) begin
            out_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_en && s1_vld_reg) begin
            out_word_reg <= {px[7:0], px[15:8]};
            out_addr_reg <= s1_addr_reg;
            out_ovf_reg  <= s1_ovf_reg;
            out_last_reg <= s1_last_reg;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {2'b00, out_word_reg, out_addr_reg};
    assign m_axis_tuser  = out_ovf_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// ===== hdl/antialiased_glyph_blend_writer.sv =====
// ----------------------------------------------------------------------------
// antialiased_glyph_blend_writer
// Blends glyph coverage bytes between two RGB565 colors and emits
// framebuffer writes.
// ----------------------------------------------------------------------------
// One coverage byte enters per cycle and one pixel write leaves per cycle
// while the output is ready; the block then sustains one word per clock with
// no bubbles. The front computes the address (one 9x8 multiply and compare)
// as the word enters a four-entry queue, then the back multiplies each
// channel by the coverage into its product register and finishes the divide
// by 255 into the output register. The queue and the two back registers let
// the input side take up to six words while the output is stalled. Colors
// and row stride should only be written while no words are in flight.
// ----------------------------------------------------------------------------
module antialiased_glyph_blend_writer #(
    parameter int BUFFER_DEPTH = 16384
) (
    input  logic        aclk,
    input  logic        aresetn,

    // Configuration (APB)
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    // Glyph coverage words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: coverage[7:0], origin_x[15:8], origin_y[23:16],
    //        glyph_width[31:24], glyph_height[39:32]
    input  logic [39:0] s_axis_tdata,
    // tuser: glyph_start[0]
    input  logic        s_axis_tuser,

    // Pixel writes
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: pixel_addr[13:0], pixel_word[29:14], zero[31:30]
    output logic [31:0] m_axis_tdata,
    // tuser: addr_overflow[0]
    output logic        m_axis_tuser,
    output logic        m_axis_tlast
);

    agbw_pkg::cfg_t          cfg_reg, cfg_next;
    agbw_pkg::cfg_reg_e      reg_sel;
    agbw_pkg::pix_item_t     push_item, head_item;
    agbw_pkg::queue_status_t q_status;
    logic                    cfg_wr, in_accept, pop;

    // Register file
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = agbw_pkg::cfg_reg_e'(paddr[3:2]);

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr) begin
            unique case (reg_sel)
                agbw_pkg::REG_FG_COLOR:   cfg_next.fg_color   = pwdata[15:0];
                agbw_pkg::REG_BG_COLOR:   cfg_next.bg_color   = pwdata[15:0];
                agbw_pkg::REG_ROW_STRIDE: cfg_next.row_stride = pwdata[7:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            agbw_pkg::REG_FG_COLOR:   prdata = {16'd0, cfg_reg.fg_color};
            agbw_pkg::REG_BG_COLOR:   prdata = {16'd0, cfg_reg.bg_color};
            agbw_pkg::REG_ROW_STRIDE: prdata = {24'd0, cfg_reg.row_stride};
            default:                  prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fg_color   <= 16'hFFFF;
            cfg_reg.bg_color   <= 16'h0000;
            cfg_reg.row_stride <= 8'd160;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Input side: accept while the queue has room
    assign s_axis_tready = !q_status.full;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    agbw_front #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .in_accept    (in_accept),
        .coverage     (s_axis_tdata[7:0]),
        .glyph_start  (s_axis_tuser),
        .origin_x     (s_axis_tdata[15:8]),
        .origin_y     (s_axis_tdata[23:16]),
        .glyph_width  (s_axis_tdata[31:24]),
        .glyph_height (s_axis_tdata[39:32]),
        .push_item    (push_item)
    );

    agbw_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (in_accept),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .status    (q_status)
    );

    agbw_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .head_item     (head_item),
        .q_status      (q_status),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

`ifndef SYNTHESIS
    // An overflowed write never carries a live address
    a_ovf_addr_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[13:0] == 14'd0))
        else $error("overflowed pixel carries nonzero address");

    // A one-pixel glyph is its own last pixel
    a_single_pixel_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && s_axis_tuser && s_axis_tdata[31:24] == 8'd1
            && s_axis_tdata[39:32] == 8'd1) |-> push_item.glyph_last)
        else $error("single pixel glyph not marked last");

    // The back never pops an empty queue
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_status.empty)
        else $error("pop from empty queue");

    // Nothing is presented in the cycle after reset
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("output valid right after reset");
`endif

endmodule

// ===== test/tb_antialiased_glyph_blend_writer.sv =====
// ----------------------------------------------------------------------------
// tb_antialiased_glyph_blend_writer
// Self-checking testbench for the glyph blend writer. Coverage words go in on
// the input stream. A scoreboard runs its own bit-accurate model of the
// blend, the address walk and the overflow flag, and checks every pixel write
// against it. The color and stride registers are set over APB between
// phases. Both stream sides idle at random, and one long output stall fills
// the internal queue.
// ----------------------------------------------------------------------------
module tb_antialiased_glyph_blend_writer;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BufferDepth = 16384;
    localparam int StallLimit  = 2000;   // cycles with no handshake at all
    localparam int PhaseWords  = 240;

    // One predicted pixel write
    typedef struct {
        logic [13:0] addr;
        logic [15:0] word;
        logic        ovf;
        logic        last;
    } pixel_write_t;

    // ------------------------------------------------------------------------
    // Scoreboard: blend and address model plus the queue of pending writes
    // ------------------------------------------------------------------------
    class glyph_blend_scoreboard;
        pixel_write_t pending_writes[$];
        int          depth;
        int          failures;
        logic [15:0] fg;
        logic [15:0] bg;
        logic [7:0]  stride;
        logic [7:0]  col;
        logic [7:0]  line;
        logic [7:0]  bx;
        logic [7:0]  by;
        logic [7:0]  wid;
        logic [7:0]  hgt;

        function new(int buf_depth);
            depth    = buf_depth;
            failures = 0;
            fg       = 16'hFFFF;
            bg       = 16'h0000;
            stride   = 8'd160;
            col      = '0;
            line     = '0;
            bx       = '0;
            by       = '0;
            wid      = 8'd1;
            hgt      = 8'd1;
        endfunction

        function void write_reg(agbw_pkg::cfg_reg_e idx, logic [31:0] value);
            case (idx)
                agbw_pkg::REG_FG_COLOR:   fg = value[15:0];
                agbw_pkg::REG_BG_COLOR:   bg = value[15:0];
                agbw_pkg::REG_ROW_STRIDE: stride = value[7:0];
                default: ;
            endcase
        endfunction

        // cov * (fg - bg) / 255 + bg, quotient truncated toward zero
        function logic [5:0] mix_channel(int cov, int f, int b);
            int diff;
            int q;
            diff = f - b;
            q    = (cov * diff) / 255;
            return 6'(q + b);
        endfunction

        function void note_input(logic [39:0] d, logic start);
            pixel_write_t e;
            int           a;
            logic [5:0]   r;
            logic [5:0]   g;
            logic [5:0]   b;
            logic [15:0]  px;
            logic         lc;
            logic         ll;
            if (start) begin
                bx   = d[15:8];
                by   = d[23:16];
                wid  = d[31:24];
                hgt  = d[39:32];
                col  = '0;
                line = '0;
            end
            a = (int'(by) + int'(line)) * int'(stride) + int'(bx) + int'(col);
            r = mix_channel(int'(d[7:0]), int'(fg[15:11]), int'(bg[15:11]));
            g = mix_channel(int'(d[7:0]), int'(fg[10:5]), int'(bg[10:5]));
            b = mix_channel(int'(d[7:0]), int'(fg[4:0]), int'(bg[4:0]));
            px = {r[4:0], g[5:0], b[4:0]};
            e.word = {px[7:0], px[15:8]};
            e.ovf  = (a >= depth);
            e.addr = e.ovf ? 14'd0 : a[13:0];
            lc = (col == wid - 8'd1);
            ll = (line == hgt - 8'd1);
            e.last = lc && ll;
            pending_writes.push_back(e);
            // walk the glyph; 8-bit counters wrap
            if (lc) begin
                col  = '0;
                line = ll ? 8'd0 : line + 8'd1;
            end else begin
                col = col + 8'd1;
            end
        endfunction

        function void check_result(logic [31:0] d, logic ovf, logic last);
            pixel_write_t e;
            if (pending_writes.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected pixel write: addr=%h word=%h ovf=%b last=%b",
                             d[13:0], d[29:14], ovf, last);
                return;
            end
            e = pending_writes.pop_front();
            if (d[13:0] !== e.addr || d[29:14] !== e.word || d[31:30] !== 2'b00 ||
                ovf !== e.ovf || last !== e.last) begin
                failures++;
                if (failures <= 10) begin
                    $write("pixel mismatch: expected addr=%h word=%h ovf=%b last=%b pad=0,",
                           e.addr, e.word, e.ovf, e.last);
                    $display(" got addr=%h word=%h ovf=%b last=%b pad=%b",
                             d[13:0], d[29:14], ovf, last, d[31:30]);
                end
            end
        endfunction

        function int pending();
            return pending_writes.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic        aclk;
    logic        aresetn       = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [3:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // tdata: coverage, origin_x, origin_y, glyph_width, glyph_height (low up)
    logic [39:0] s_axis_tdata  = '0;
    // tuser: glyph_start
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // tdata: pixel_addr, pixel_word, zero pad (low up)
    logic [31:0] m_axis_tdata;
    // tuser: addr_overflow
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    glyph_blend_scoreboard sb;
    int tx_calm   = 0;
    int idle_runs = 0;

    antialiased_glyph_blend_writer #(
        .BUFFER_DEPTH(BufferDepth)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 10 ns clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: feed accepted words to the scoreboard
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_input(s_axis_tdata, s_axis_tuser);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
    end

    // Watchdog: cycles with no handshake anywhere
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable) || !aresetn) begin
            idle_runs <= 0;
        end else if (idle_runs >= StallLimit) begin
            $display("antialiased_glyph_blend_writer regression: fail");
            $finish;
        end else begin
            idle_runs <= idle_runs + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random ready, calm stretches, one long hold-off
    // ------------------------------------------------------------------------
    initial begin
        int  rx_cycles;
        int  hi;
        int  gap;
        bit  held;
        rx_cycles = 0;
        held      = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!held && rx_cycles >= 400) begin
                // long stall while the sender keeps offering
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                rx_cycles += 300;
                held = 1'b1;
            end
            hi = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 150)
                                              : $urandom_range(1, 8);
            m_axis_tready <= 1'b1;
            repeat (hi) @(posedge aclk);
            rx_cycles += hi;
            gap = pick_gap();
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
                rx_cycles += gap;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic apb_write(agbw_pkg::cfg_reg_e idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        sb.write_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // one coverage word, held until accepted, then a random gap outside calm runs
    task automatic send_px(logic [7:0] cov, logic start, logic [7:0] ox, logic [7:0] oy,
                           logic [7:0] w, logic [7:0] h);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {h, w, oy, ox, cov};
        s_axis_tuser  <= start;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        if (tx_calm > 0) begin
            tx_calm--;
            gap = 0;
        end else begin
            if ($urandom_range(0, 49) == 0) tx_calm = $urandom_range(20, 80);
            gap = pick_gap();
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // glyph word: start on the first one, junk geometry on the rest
    task automatic send_glyph(logic [7:0] ox, logic [7:0] oy, logic [7:0] w, logic [7:0] h,
                              int count);
        for (int i = 0; i < count; i++) begin
            if (i == 0)
                send_px(8'($urandom), 1'b1, ox, oy, w, h);
            else
                send_px(8'($urandom), 1'b0, 8'($urandom), 8'($urandom),
                        8'($urandom), 8'($urandom));
        end
    endtask

    // drop valid and wait for every pending write plus the pipeline tail
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic run_random(int words);
        int sent;
        int r;
        int w;
        int h;
        int n;
        logic [7:0] oy;
        sent = 0;
        while (sent < words) begin
            r = $urandom_range(0, 99);
            if (r < 75) begin
                // well-formed small glyph, sometimes cut short or walked again
                w  = $urandom_range(1, 10);
                h  = $urandom_range(1, 5);
                oy = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 40));
                n  = w * h;
                r  = $urandom_range(0, 9);
                if (r == 0) n = $urandom_range(1, w * h);
                else if (r == 1) n = w * h + $urandom_range(1, w * h);
                send_glyph(8'($urandom), oy, 8'(w), 8'(h), n);
            end else if (r < 85) begin
                // full-range geometry, only the first pixels
                n = $urandom_range(1, 16);
                send_glyph(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), n);
            end else begin
                n = 1;
                send_px(8'($urandom), 1'($urandom), 8'($urandom), 8'($urandom),
                        8'($urandom), 8'($urandom));
            end
            sent += n;
        end
    endtask

    task automatic set_colors(logic [31:0] fgv, logic [31:0] bgv, logic [31:0] stv);
        apb_write(agbw_pkg::REG_FG_COLOR, fgv);
        apb_write(agbw_pkg::REG_BG_COLOR, bgv);
        apb_write(agbw_pkg::REG_ROW_STRIDE, stv);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        sb = new(BufferDepth);
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // pixels before any glyph start: 1x1 glyph at the origin
        send_px(8'h00, 1'b0, 8'hFF, 8'h00, 8'hFF, 8'h00);
        send_px(8'hFF, 1'b0, 8'h00, 8'hFF, 8'h00, 8'hFF);
        send_px(8'hA5, 1'b0, 8'h5A, 8'hA5, 8'h5A, 8'hA5);
        // far corner overflows
        send_px(8'hFF, 1'b1, 8'hFF, 8'hFF, 8'd1, 8'd1);
        // 3x2 glyph, then two pixels past its end
        send_px(8'h00, 1'b1, 8'd0, 8'd0, 8'd3, 8'd2);
        send_px(8'hFF, 1'b0, 8'hAA, 8'h55, 8'hAA, 8'h55);
        send_px(8'h80, 1'b0, 8'h55, 8'hAA, 8'h55, 8'hAA);
        send_px(8'h01, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
        send_px(8'hFE, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_px(8'h55, 1'b0, 8'h12, 8'h34, 8'h56, 8'h78);
        send_px(8'h7F, 1'b0, 8'h9A, 8'hBC, 8'hDE, 8'hF0);
        send_px(8'hAA, 1'b0, 8'h0F, 8'hF0, 8'h0F, 8'hF0);
        // last address below the buffer depth, then the first one at it
        send_px(8'h40, 1'b1, 8'd63, 8'd102, 8'd2, 8'd1);
        send_px(8'hC0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
        // zero width acts as 256 columns
        send_px(8'h11, 1'b1, 8'd10, 8'd5, 8'd0, 8'd1);
        send_px(8'h22, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
        send_px(8'h33, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
        // zero height acts as 256 lines
        send_px(8'h44, 1'b1, 8'd200, 8'd0, 8'd1, 8'd0);
        send_px(8'h66, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
        send_px(8'h99, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
        // largest glyph size
        send_px(8'hFF, 1'b1, 8'd0, 8'd0, 8'd255, 8'd255);
        drain();

        // inverted extremes, unit stride, junk in the upper data bits
        set_colors({16'hA5A5, 16'h0000}, {16'h5A5A, 16'hFFFF}, {24'hFFFFFF, 8'd1});
        send_glyph(8'd255, 8'd255, 8'd2, 8'd2, 4);
        run_random(PhaseWords);
        drain();

        set_colors(32'h0000F800, 32'h000007E0, 32'h000000FF);
        send_glyph(8'd0, 8'd255, 8'd4, 8'd1, 4);
        run_random(PhaseWords);
        drain();

        // zero stride: address is origin_x plus column
        set_colors($urandom, $urandom, {$urandom_range(0, 32'hFFFFFF) << 8});
        run_random(PhaseWords);
        drain();

        set_colors($urandom, $urandom, $urandom_range(1, 255));
        run_random(PhaseWords);
        drain();

        set_colors(32'h0000FFFF, 32'h0000FFFF, 32'd160);
        run_random(PhaseWords / 2);
        drain();

        set_colors(32'h00000000, 32'h00000000, 32'd160);
        run_random(PhaseWords / 2);
        drain();

        if (sb.pending() != 0) sb.failures++;
        if (sb.failures == 0) begin
            $display("antialiased_glyph_blend_writer regression: pass");
        end else begin
            $display("antialiased_glyph_blend_writer regression: fail");
        end
        $finish;
    end

endmodule
